### hw/rtl/rsa_pkg.sv
// Shared types and constants for the ring slot allocator.
// Holds the item structs, operation codes and the default pool size.
// No dependencies.
`default_nettype none

package rsa_pkg;

  // Default number of slots in the ring.
  localparam int POOL_SLOTS_DEF = 256;

  // Width of the slot number field on the input item.
  localparam int TASK_ID_W = 16;

  // Width of the slot number returned on the result item.
  localparam int RESULT_ID_W = 8;

  // Operation codes carried in the op field.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // One request item.
  typedef struct packed {
    logic [1:0]           op;
    logic [TASK_ID_W-1:0] task_id;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [RESULT_ID_W-1:0] result_id;
    logic                   success;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/rsa_flag_mem.sv
// Live-flag memory of the ring slot allocator: one write port, one read port,
// registered read data. No dependencies.
`default_nettype none

module rsa_flag_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/rsa_idx_unit.sv
// Shared ring index unit: wraps an index forward and compares it.
// Used by the sequencer for the head advance, the tail walk and the clear sweep.
`default_nettype none

module rsa_idx_unit #(
  parameter int POOL_SLOTS = 256,
  parameter int AW         = 8
) (
  input  wire logic [AW-1:0] idx_a,
  input  wire logic [AW-1:0] idx_b,
  output logic [AW-1:0]      a_nxt,
  output logic               a_last,
  output logic               a_eq_b,
  output logic               nxt_eq_b
);

  localparam logic [AW-1:0] LastIdx = AW'(POOL_SLOTS - 1);

  // Next index around the ring, plus the two compares the sequencer needs.
  always_comb begin
    a_last   = (idx_a == LastIdx);
    a_nxt    = a_last ? '0 : idx_a + AW'(1);
    a_eq_b   = (idx_a == idx_b);
    nxt_eq_b = (a_nxt == idx_b);
  end

endmodule

`default_nettype wire

### hw/rtl/rsa_seq.sv
// Sequencer of the ring slot allocator: holds head and tail, runs the clear
// sweep, allocate, free with tail walk, and query. Uses rsa_pkg, rsa_idx_unit
// and rsa_flag_mem.
`default_nettype none

module rsa_seq #(
  parameter int POOL_SLOTS = rsa_pkg::POOL_SLOTS_DEF,
  parameter int AW         = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire rsa_pkg::in_item_t req_item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output rsa_pkg::out_item_t     res_item
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_WCHK,
    ST_QRD,
    ST_RESP
  } state_t;

  state_t                            state_r, state_nxt;
  logic [AW-1:0]                     head_r, head_nxt;
  logic [AW-1:0]                     tail_r, tail_nxt;
  logic [1:0]                        op_r, op_nxt;
  logic [rsa_pkg::TASK_ID_W-1:0]     id_r, id_nxt;
  rsa_pkg::out_item_t                res_r, res_nxt;

  logic [AW-1:0] ua, ub, u_nxt;
  logic          u_last, u_eq, u_nxt_eq;

  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic                            in_range;
  logic [AW-1:0]                   id_idx;
  logic [rsa_pkg::TASK_ID_W-1:0]   head_ext;

  assign in_range = (id_r < rsa_pkg::TASK_ID_W'(POOL_SLOTS));
  assign id_idx   = id_r[AW-1:0];
  assign head_ext = rsa_pkg::TASK_ID_W'(head_r);

  // The shared unit works on the head during execute, on the tail otherwise.
  assign ua = (state_r == ST_EXEC) ? head_r : tail_r;
  assign ub = (state_r == ST_EXEC) ? tail_r : head_r;

  rsa_idx_unit #(
    .POOL_SLOTS (POOL_SLOTS),
    .AW         (AW)
  ) u_idx (
    .idx_a    (ua),
    .idx_b    (ub),
    .a_nxt    (u_nxt),
    .a_last   (u_last),
    .a_eq_b   (u_eq),
    .nxt_eq_b (u_nxt_eq)
  );

  rsa_flag_mem #(
    .DEPTH (POOL_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res_item  = res_r;

  // Next-state and datapath control.
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    op_nxt    = op_r;
    id_nxt    = id_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = 1'b0;
    mem_raddr = tail_r;

    unique case (state_r)
      // Clear sweep: the tail register serves as the address counter and
      // wraps back to zero after the last slot.
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = tail_r;
        tail_nxt  = u_nxt;
        if (u_last) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          op_nxt    = req_item.op;
          id_nxt    = req_item.task_id;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_nxt.result_id = id_r[rsa_pkg::RESULT_ID_W-1:0];
        res_nxt.success   = 1'b0;
        state_nxt         = ST_RESP;
        unique case (op_r)
          rsa_pkg::OP_ALLOC: begin
            res_nxt.result_id = '0;
            // Full when the head would step onto the tail.
            if (!u_nxt_eq) begin
              mem_we            = 1'b1;
              mem_waddr         = head_r;
              mem_wdata         = 1'b1;
              head_nxt          = u_nxt;
              res_nxt.result_id = head_ext[rsa_pkg::RESULT_ID_W-1:0];
              res_nxt.success   = 1'b1;
            end
          end
          rsa_pkg::OP_FREE: begin
            if (in_range) begin
              mem_we          = 1'b1;
              mem_waddr       = id_idx;
              mem_wdata       = 1'b0;
              res_nxt.success = 1'b1;
              state_nxt       = ST_WALK;
            end
          end
          rsa_pkg::OP_QUERY: begin
            if (in_range) begin
              mem_raddr = id_idx;
              state_nxt = ST_QRD;
            end
          end
          default: begin
            res_nxt.success = 1'b0;
          end
        endcase
      end

      // Tail walk: stop at the head, otherwise fetch the flag under the tail.
      ST_WALK: begin
        mem_raddr = tail_r;
        state_nxt = u_eq ? ST_RESP : ST_WCHK;
      end

      // A live slot ends the walk; a cleared one moves the tail on.
      ST_WCHK: begin
        if (mem_rdata) begin
          state_nxt = ST_RESP;
        end else begin
          tail_nxt  = u_nxt;
          state_nxt = ST_WALK;
        end
      end

      ST_QRD: begin
        res_nxt.success = mem_rdata;
        state_nxt       = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, indices and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
    op_r  <= op_nxt;
    id_r  <= id_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/ring_slot_allocator_in_order_reclaim.sv
// Ring slot allocator with in-order handout and out-of-order reclaim.
//
// Requests enter on in_valid/in_ready with an in_data item (op, task_id);
// one result item leaves on out_valid/out_ready per request. Allocate hands
// out the head slot unless tail to head already spans POOL_SLOTS-1 slots;
// free clears a slot and walks the tail over cleared slots; query reads a flag.
//
// Allocate, out-of-range requests and unused op codes go from the execute
// state straight to the response state; a query passes through a flag read
// state first, and a free walks the tail in a walk state and a check state
// per slot until it meets the head or a live slot. in_ready rises together
// with out_valid; a new request is taken only once the previous result has
// left the sequencer. The walk reads the flag memory through the read port.
//
// After reset the flag memory is cleared one slot per cycle, so in_ready
// stays low until the sweep ends. A result waits in the output register
// while out_ready is low; the next request is still taken and worked on,
// and then holds in the sequencer until the output register frees up.
// Depends on rsa_pkg, rsa_seq, rsa_idx_unit and rsa_flag_mem.
`default_nettype none

module ring_slot_allocator_in_order_reclaim #(
  parameter int POOL_SLOTS = rsa_pkg::POOL_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rsa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rsa_pkg::out_item_t      out_data
);

  localparam int IdxW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  logic               res_valid, res_ready;
  rsa_pkg::out_item_t res_item;
  logic               out_valid_r;
  rsa_pkg::out_item_t out_data_r;

  rsa_seq #(
    .POOL_SLOTS (POOL_SLOTS),
    .AW         (IdxW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req_item  (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### tb/slot_ledger_pkg.sv
// Scoreboard class for the ring slot allocator testbench.
// Mirrors the slot flags and ring indexes and checks each result item in order.
// Depends on rsa_pkg.
`timescale 1ns / 1ps

package slot_ledger_pkg;
  import rsa_pkg::*;

  // Op code that the block does not decode.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned SLOTS = rsa_pkg::POOL_SLOTS_DEF;

  class slot_ledger;
    bit          live_flag [SLOTS];
    int unsigned head;
    int unsigned tail;
    out_item_t   expected_q[$];
    int          mismatches;

    function new();
      foreach (live_flag[i]) live_flag[i] = 1'b0;
      head       = 0;
      tail       = 0;
      mismatches = 0;
    endfunction

    function int unsigned next_slot(int unsigned i);
      return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    // Number of slots between tail and head, live or already freed.
    function int unsigned live_span();
      return (head + SLOTS - tail) % SLOTS;
    endfunction

    // Apply one accepted request to the mirrored state and queue its result.
    function void note_request(in_item_t req);
      out_item_t   res;
      int unsigned id;
      id            = 32'(req.task_id);
      res.result_id = req.task_id[RESULT_ID_W-1:0];
      res.success   = 1'b0;
      case (req.op)
        OP_ALLOC: begin
          res.result_id = '0;
          if (next_slot(head) != tail) begin
            res.result_id   = head[RESULT_ID_W-1:0];
            res.success     = 1'b1;
            live_flag[head] = 1'b1;
            head            = next_slot(head);
          end
        end
        OP_FREE: begin
          if (id < SLOTS) begin
            live_flag[id] = 1'b0;
            // Reclaim cleared slots at the tail until a live one or the head.
            for (int g = 0; g < SLOTS; g++) begin
              if (tail == head || live_flag[tail]) break;
              tail = next_slot(tail);
            end
            res.success = 1'b1;
          end
        end
        OP_QUERY: begin
          if (id < SLOTS && live_flag[id]) res.success = 1'b1;
        end
        default: begin
        end
      endcase
      expected_q.push_back(res);
    endfunction

    // Compare one result item against the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing expected: result_id %0d success %0b",
                   $realtime, got.result_id, got.success);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.result_id !== want.result_id || got.success !== want.success) begin
        if (mismatches < 10)
          $display("%0t: result mismatch: result_id exp %0d got %0d, success %0b/%0b",
                   $realtime, want.result_id, got.result_id, want.success, got.success);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### tb/ring_slot_allocator_in_order_reclaim_test.sv
// Testbench top for the ring slot allocator with in-order reclaim.
// Drives requests through valid/ready and checks results with slot_ledger.
// Depends on rsa_pkg, slot_ledger_pkg and ring_slot_allocator_in_order_reclaim.
`timescale 1ns / 1ps

module ring_slot_allocator_in_order_reclaim_test;
  import rsa_pkg::*;
  import slot_ledger_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  slot_ledger ledger;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         stall_cycles;

  ring_slot_allocator_in_order_reclaim u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock generation, 8 ns period.
  always #4 clk = ~clk;

  function automatic in_item_t make_request(logic [1:0] op, logic [TASK_ID_W-1:0] id);
    in_item_t req;
    req.op      = op;
    req.task_id = id;
    return req;
  endfunction

  // Random request; frees are weighted toward slots inside the live window.
  function automatic in_item_t make_random_item();
    int unsigned roll;
    int unsigned span;
    int unsigned slot;
    roll = $urandom_range(0, 99);
    span = ledger.live_span();
    if (roll < 40)
      return make_request(OP_ALLOC, TASK_ID_W'($urandom_range(0, 65535)));
    if (roll < 75) begin
      if (span != 0 && $urandom_range(0, 9) < 8)
        slot = (ledger.tail + $urandom_range(0, span - 1)) % SLOTS;
      else
        slot = $urandom_range(0, SLOTS - 1);
      return make_request(OP_FREE, TASK_ID_W'(slot));
    end
    if (roll < 93) begin
      if ($urandom_range(0, 9) < 6)
        return make_request(OP_QUERY, TASK_ID_W'($urandom_range(0, SLOTS - 1)));
      return make_request(OP_QUERY, TASK_ID_W'($urandom_range(0, 65535)));
    end
    if ($urandom_range(0, 1) == 0)
      return make_request(OP_UNUSED, TASK_ID_W'($urandom_range(0, 65535)));
    return make_request(OP_FREE, TASK_ID_W'($urandom_range(SLOTS, 65535)));
  endfunction

  // Offer one item, with random idle cycles ahead of it, until it is accepted.
  task automatic send_request(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_request(item);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_request(make_random_item());
  endtask

  // Hold off new items until every outstanding result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.expected_q.size() != 0);
  endtask

  // Result side: check accepted items and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_result(out_data);
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d cycles without a handshake", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned drain_slots[$];
    int unsigned pick;
    int unsigned swap_slot;
    int unsigned slot;

    ledger        = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    stall_cycles  = 0;
    send_idle_pct = 31;
    recv_idle_pct = 73;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: grants, out-of-order frees, tail walks and edge cases.
    send_request(make_request(OP_QUERY, 16'd0));
    send_request(make_request(OP_ALLOC, 16'hFFFF));
    send_request(make_request(OP_ALLOC, 16'd0));
    send_request(make_request(OP_ALLOC, 16'd0));
    send_request(make_request(OP_QUERY, 16'd1));
    // Freeing a slot behind a live tail leaves the tail in place.
    send_request(make_request(OP_FREE, 16'd1));
    send_request(make_request(OP_QUERY, 16'd1));
    // Freeing the tail slot walks over the already freed one.
    send_request(make_request(OP_FREE, 16'd0));
    // A slot that is not live is still accepted.
    send_request(make_request(OP_FREE, 16'd200));
    send_request(make_request(OP_FREE, 16'd2));
    // Out-of-range slot numbers and the unused op code.
    send_request(make_request(OP_FREE, 16'd256));
    send_request(make_request(OP_FREE, 16'hFFFF));
    send_request(make_request(OP_QUERY, 16'h8000));
    send_request(make_request(OP_UNUSED, 16'hAAAA));
    send_request(make_request(OP_UNUSED, 16'h5555));
    send_request(make_request(OP_QUERY, 16'd255));
    send_request(make_request(OP_ALLOC, 16'h1234));
    // Out-of-range query whose low byte names a live slot.
    send_request(make_request(OP_QUERY, 16'h0103));
    send_request(make_request(OP_FREE, 16'd3));

    send_random(150);

    // Let every outstanding result come back before switching the idle pattern.
    wait_for_results();
    send_idle_pct = 73;
    recv_idle_pct = 31;

    send_random(30);

    // Fill the ring to its limit, try past it, then free everything in random order.
    while (ledger.live_span() != SLOTS - 1)
      send_request(make_request(OP_ALLOC, TASK_ID_W'($urandom_range(0, 65535))));
    send_request(make_request(OP_ALLOC, 16'd0));
    send_request(make_request(OP_ALLOC, 16'hFFFF));
    for (int k = 0; k < SLOTS - 1; k++) begin
      slot = (ledger.tail + k) % SLOTS;
      if (ledger.live_flag[slot]) drain_slots.push_back(slot);
    end
    for (int k = drain_slots.size() - 1; k > 0; k--) begin
      pick              = $urandom_range(0, k);
      swap_slot         = drain_slots[k];
      drain_slots[k]    = drain_slots[pick];
      drain_slots[pick] = swap_slot;
    end
    foreach (drain_slots[k]) begin
      send_request(make_request(OP_FREE, TASK_ID_W'(drain_slots[k])));
      if ($urandom_range(0, 9) == 0)
        send_request(make_request(OP_QUERY, TASK_ID_W'($urandom_range(0, SLOTS - 1))));
    end

    send_random(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(100);

    // Drain and give the block time to show any result that is not owed.
    wait_for_results();
    repeat (40) @(posedge clk);

    if (ledger.mismatches == 0 && ledger.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
